// File: src/counter_delta_rate_meter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the counter delta rate meter
// Shared helpers for writing concurrent checks with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef COUNTER_DELTA_RATE_METER_UNIT_ASSERT_SVH
`define COUNTER_DELTA_RATE_METER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDRM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cdrm_pkg.sv
// ----------------------------------------------------------------------------
// cdrm_pkg
// Widths, constants and shared types of the counter delta rate meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdrm_pkg;

  localparam int SEC_W    = 32;
  localparam int USEC_W   = 20;
  localparam int COUNT_W  = 64;
  localparam int RATE_W   = 48;
  localparam int WARM_W   = 8;
  localparam int HALF_W   = COUNT_W / 2;
  localparam int PROD_W   = HALF_W + USEC_W;      // one half of a delta times 10^6
  localparam int TIME_W   = SEC_W + USEC_W;       // timestamp in microseconds
  localparam int NUM_W    = PROD_W + HALF_W;      // full delta times 10^6
  localparam int DIV_CNT_W = $clog2(RATE_W);

  localparam logic [USEC_W-1:0] US_PER_S     = USEC_W'(1000000);
  localparam logic [WARM_W-1:0] WARMUP_RESET = WARM_W'(8);
  localparam logic [WARM_W-1:0] WARMUP_MAX   = '1;

  typedef enum logic [1:0] {
    STATUS_BASELINE = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_WARMUP   = 2'd2,
    STATUS_PEAK     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_CHECK,
    ST_WAIT,
    ST_RESULT
  } top_state_t;

  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_MUL_LO,
    LANE_MUL_HI,
    LANE_SUM,
    LANE_SAT,
    LANE_DIV
  } lane_state_t;

  typedef struct packed {
    logic commit;
    logic track;
  } merge_ctl_t;

endpackage

`default_nettype wire

// File: src/cdrm_lane.sv
// ----------------------------------------------------------------------------
// cdrm_lane
// One direction: scales a byte delta by 10^6 and divides it by the time span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdrm_lane import cdrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COUNT_W-1:0] delta_in,
  input  logic [TIME_W-1:0]  span_in,
  output logic               busy,
  output logic [RATE_W-1:0]  rate
);

  lane_state_t state, state_next;

  logic [COUNT_W-1:0]   delta;
  logic [TIME_W-1:0]    span;
  logic [PROD_W-1:0]    p_lo;
  logic [PROD_W-1:0]    p_hi;
  logic [NUM_W-1:0]     num;
  logic [TIME_W-1:0]    rem;
  logic [RATE_W-1:0]    quo;
  logic                 sat;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [PROD_W-1:0] mul_lo, mul_hi;
  logic [TIME_W-1:0] num_top;
  logic              sat_now;
  logic [TIME_W:0]   trial, diff;
  logic              ge;

  assign mul_lo  = delta[HALF_W-1:0] * US_PER_S;
  assign mul_hi  = delta[COUNT_W-1:HALF_W] * US_PER_S;
  assign num_top = TIME_W'(num[NUM_W-1:RATE_W]);
  // The quotient cannot fit in the rate field once the top of the numerator
  // reaches the divisor.
  assign sat_now = num_top >= span;

  assign trial = {rem, quo[RATE_W-1]};
  assign diff  = trial - {1'b0, span};
  assign ge    = trial >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      LANE_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = LANE_MUL_LO;
        end
      end
      LANE_MUL_LO: state_next = LANE_MUL_HI;
      LANE_MUL_HI: state_next = LANE_SUM;
      LANE_SUM:    state_next = LANE_SAT;
      LANE_SAT: begin
        state_next = sat_now ? LANE_IDLE : LANE_DIV;
      end
      LANE_DIV: begin
        if (div_cnt == DIV_CNT_W'(RATE_W - 1)) begin
          state_next = LANE_IDLE;
        end
      end
      default: state_next = LANE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      LANE_IDLE: begin
        if (start) begin
          delta <= delta_in;
          span  <= span_in;
        end
      end
      LANE_MUL_LO: p_lo <= mul_lo;
      LANE_MUL_HI: p_hi <= mul_hi;
      LANE_SUM:    num  <= NUM_W'(p_lo) + {p_hi, {HALF_W{1'b0}}};
      LANE_SAT: begin
        sat     <= sat_now;
        rem     <= num_top;
        quo     <= num[RATE_W-1:0];
        div_cnt <= '0;
      end
      LANE_DIV: begin
        rem     <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        quo     <= {quo[RATE_W-2:0], ge};
        div_cnt <= div_cnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign rate = sat ? '1 : quo;

endmodule

`default_nettype wire

// File: src/cdrm_merge.sv
// ----------------------------------------------------------------------------
// cdrm_merge
// Combines the two lane rates into the receive and transmit peak holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdrm_merge import cdrm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  merge_ctl_t        ctl,
  input  logic [RATE_W-1:0] rx_rate_in,
  input  logic [RATE_W-1:0] tx_rate_in,
  output logic [RATE_W-1:0] rx_peak_new,
  output logic [RATE_W-1:0] tx_peak_new
);

  logic [RATE_W-1:0] rx_hold;
  logic [RATE_W-1:0] tx_hold;

  // Peak values as they stand after the result now being committed.
  assign rx_peak_new = (ctl.track && rx_rate_in > rx_hold) ? rx_rate_in : rx_hold;
  assign tx_peak_new = (ctl.track && tx_rate_in > tx_hold) ? tx_rate_in : tx_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_hold <= '0;
      tx_hold <= '0;
    end else if (ctl.commit) begin
      rx_hold <= rx_peak_new;
      tx_hold <= tx_peak_new;
    end
  end

endmodule

`default_nettype wire

// File: src/counter_delta_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// counter_delta_rate_meter_unit
// Byte counter snapshot rate meter with warm-up and peak hold.
// ----------------------------------------------------------------------------
// Each input item is a timestamped snapshot of the receive and transmit byte
// counters. The first item after reset only sets the baseline (status 0, zero
// rates). Every later item gives, per direction, the rate
// floor(byte delta * 1000000 / microsecond delta) in bytes per second,
// saturated at 2^48-1. A zero or backward time step or a counter that goes
// down gives status 1 with zero rates; the item still becomes the new
// baseline. A warm-up count, saturating at 255, counts items after the first;
// once it reaches the warmup_samples register (reset value 8) the peak holds
// follow the rates and the status is 3, before that it is 2. The block works
// on one item at a time. A measured item goes through the multiply stages
// and then the two 48-step bit-serial dividers (one per direction, running
// side by side). When both directions saturate, the divide is skipped.
// Invalid and baseline items do not start the lanes. The next item can be
// taken in the cycle after a result is loaded. A finished result sits in the
// output register while the next item is already accepted and processed.
// Write the warm-up register only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module counter_delta_rate_meter_unit import cdrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel (warm-up setting).
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WARM_W-1:0]  cfg_data,
  // Snapshot input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SEC_W-1:0]   time_seconds,
  input  logic [USEC_W-1:0]  time_microseconds,
  input  logic [COUNT_W-1:0] rx_byte_count,
  input  logic [COUNT_W-1:0] tx_byte_count,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RATE_W-1:0]  rx_rate,
  output logic [RATE_W-1:0]  tx_rate,
  output logic [RATE_W-1:0]  rx_peak,
  output logic [RATE_W-1:0]  tx_peak,
  output logic [1:0]         status
);

  top_state_t state, state_next;

  // Snapshot captured at accept.
  logic [SEC_W-1:0]   sec_q;
  logic [USEC_W-1:0]  usec_q;
  logic [COUNT_W-1:0] rx_q;
  logic [COUNT_W-1:0] tx_q;
  logic [TIME_W-1:0]  t_new;

  // Previous snapshot and warm-up state. The old timestamp is kept already
  // converted to microseconds.
  logic [TIME_W-1:0]  t_old;
  logic [COUNT_W-1:0] last_rx;
  logic [COUNT_W-1:0] last_tx;
  logic               has_baseline;
  logic [WARM_W-1:0]  warmup_count;
  logic [WARM_W-1:0]  warmup_samples;

  status_t            res_status;

  logic               step_bad;
  logic [WARM_W-1:0]  warmup_next;
  logic               lane_start;
  logic               out_load;
  logic               res_measured;
  logic               rx_busy, tx_busy;
  logic [RATE_W-1:0]  rx_lane_rate, tx_lane_rate;
  logic [RATE_W-1:0]  rx_sel, tx_sel;
  logic [RATE_W-1:0]  rx_peak_new, tx_peak_new;
  merge_ctl_t         merge_ctl;

  assign cfg_ready = 1'b1;

  // A step is unusable when time does not move forward or a counter drops.
  assign step_bad = (t_new <= t_old) || (rx_q < last_rx) || (tx_q < last_tx);
  assign warmup_next = (warmup_count == WARMUP_MAX) ? warmup_count : warmup_count + 1'b1;

  assign res_measured = (res_status == STATUS_WARMUP) || (res_status == STATUS_PEAK);
  assign rx_sel = res_measured ? rx_lane_rate : '0;
  assign tx_sel = res_measured ? tx_lane_rate : '0;

  assign merge_ctl.commit = out_load;
  assign merge_ctl.track  = (res_status == STATUS_PEAK);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    lane_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_TIME;
        end
      end
      ST_TIME: state_next = ST_CHECK;
      ST_CHECK: begin
        if (has_baseline && !step_bad) begin
          lane_start = 1'b1;
          state_next = ST_WAIT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_WAIT: begin
        if (!rx_busy && !tx_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // The output register frees up in the same cycle it is taken.
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Baseline, warm-up and configuration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_old          <= '0;
      last_rx        <= '0;
      last_tx        <= '0;
      has_baseline   <= 1'b0;
      warmup_count   <= '0;
      warmup_samples <= WARMUP_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        warmup_samples <= cfg_data;
      end
      if (state == ST_CHECK) begin
        // Every snapshot becomes the baseline of the next one, good or bad.
        has_baseline <= 1'b1;
        t_old        <= t_new;
        last_rx      <= rx_q;
        last_tx      <= tx_q;
        if (has_baseline) begin
          warmup_count <= warmup_next;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item data path.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      sec_q  <= time_seconds;
      usec_q <= time_microseconds;
      rx_q   <= rx_byte_count;
      tx_q   <= tx_byte_count;
    end
    if (state == ST_TIME) begin
      t_new <= sec_q * US_PER_S + TIME_W'(usec_q);
    end
    if (state == ST_CHECK) begin
      if (!has_baseline) begin
        res_status <= STATUS_BASELINE;
      end else if (step_bad) begin
        res_status <= STATUS_INVALID;
      end else if (warmup_next >= warmup_samples) begin
        res_status <= STATUS_PEAK;
      end else begin
        res_status <= STATUS_WARMUP;
      end
    end
    if (out_load) begin
      rx_rate <= rx_sel;
      tx_rate <= tx_sel;
      rx_peak <= rx_peak_new;
      tx_peak <= tx_peak_new;
      status  <= res_status;
    end
  end

  // The lanes latch their delta and span from the old baseline on the same
  // edge that replaces it.
  cdrm_lane u_rx_lane (
    .clk      (clk),
    .rst      (rst),
    .start    (lane_start),
    .delta_in (rx_q - last_rx),
    .span_in  (t_new - t_old),
    .busy     (rx_busy),
    .rate     (rx_lane_rate)
  );

  cdrm_lane u_tx_lane (
    .clk      (clk),
    .rst      (rst),
    .start    (lane_start),
    .delta_in (tx_q - last_tx),
    .span_in  (t_new - t_old),
    .busy     (tx_busy),
    .rate     (tx_lane_rate)
  );

  cdrm_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (merge_ctl),
    .rx_rate_in  (rx_sel),
    .tx_rate_in  (tx_sel),
    .rx_peak_new (rx_peak_new),
    .tx_peak_new (tx_peak_new)
  );

  `include "counter_delta_rate_meter_unit_assert.svh"

  `CDRM_ASSERT_SAME(a_lanes_idle_at_accept, in_ready, !rx_busy && !tx_busy, "lane busy while accepting an item")
  `CDRM_ASSERT_NEXT(a_result_holds, state == ST_RESULT && out_valid && !out_ready, state == ST_RESULT, "result left before output was free")
  `CDRM_ASSERT_SAME(a_peak_covers_rate, out_valid && status == STATUS_PEAK, rx_peak >= rx_rate && tx_peak >= tx_rate, "peak below reported rate")
  `CDRM_ASSERT_SAME(a_unmeasured_zero, out_valid && (status == STATUS_BASELINE || status == STATUS_INVALID), rx_rate == '0 && tx_rate == '0, "nonzero rate on unmeasured item")

endmodule

`default_nettype wire
